### rtl/npc_pkg.sv
// ---------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette color block
// Beat layouts for the query and result channels, the record passed along
// the cell chain, and the search constants.
// ---------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

	// Field widths fixed by the channel layout
	localparam int CHAN_W = 8;
	localparam int IDX_W  = 8;
	localparam int SQ_W   = 2 * CHAN_W;
	localparam int DIST_W = 18;

	// Palette size limits
	localparam int STORE_DEPTH             = 256;
	localparam int PALETTE_ENTRIES_DEFAULT = 256;

	// Starting distance: one above the largest possible squared distance
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 3 + 1);

	// Operation carried by an input beat
	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// Query channel beat
	typedef struct packed {
		func_t             func;
		logic [IDX_W-1:0]  entry_index;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} in_beat_t;

	// Result channel beat
	typedef struct packed {
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
	} out_beat_t;

	// Record handed from cell to cell
	typedef struct packed {
		logic              valid;
		func_t             func;
		logic [IDX_W-1:0]  entry_index;
		rgb_t              color;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_dist;
	} link_t;

endpackage

`default_nettype wire

### rtl/npc_stream_if.sv
// ---------------------------------------------------------------------------
// npc_stream_if: valid/ready stream channel
// Carries one payload of type T per beat; a beat moves on a clock edge
// with valid and ready both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface npc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/npc_cell.sv
// ---------------------------------------------------------------------------
// npc_cell: one palette entry of the search chain
// Holds one palette color, captures it from a passing write beat, and
// folds its distance to a passing query into the running best.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
	parameter int CELL_INDEX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire npc_pkg::link_t link_in,
	output npc_pkg::link_t     link_out
);

	localparam logic [npc_pkg::IDX_W-1:0] CELL_ID = npc_pkg::IDX_W'(CELL_INDEX);

	npc_pkg::rgb_t                  entry_q;
	logic                           write_hit;
	logic [npc_pkg::CHAN_W-1:0]     diff_r, diff_g, diff_b;
	logic [npc_pkg::SQ_W-1:0]       sq_r, sq_g, sq_b;

	logic                           vld_s1;
	npc_pkg::link_t                 pay_s1;
	logic [npc_pkg::SQ_W-1:0]       sq_r_s1, sq_g_s1, sq_b_s1;

	logic [npc_pkg::DIST_W-1:0]     dist_sum;
	logic                           closer;
	npc_pkg::link_t                 pay_next;

	logic                           vld_s2;
	npc_pkg::link_t                 pay_s2;

	// Write beat addressed to this cell
	assign write_hit = advance && link_in.valid && (link_in.func == npc_pkg::FUNC_WRITE)
		&& (link_in.entry_index == CELL_ID);

	// Per-channel absolute difference and square against the stored entry
	always_comb begin
		diff_r = (entry_q.red > link_in.color.red) ? entry_q.red - link_in.color.red
			: link_in.color.red - entry_q.red;
		diff_g = (entry_q.green > link_in.color.green) ? entry_q.green - link_in.color.green
			: link_in.color.green - entry_q.green;
		diff_b = (entry_q.blue > link_in.color.blue) ? entry_q.blue - link_in.color.blue
			: link_in.color.blue - entry_q.blue;
		sq_r = npc_pkg::SQ_W'(diff_r) * npc_pkg::SQ_W'(diff_r);
		sq_g = npc_pkg::SQ_W'(diff_g) * npc_pkg::SQ_W'(diff_g);
		sq_b = npc_pkg::SQ_W'(diff_b) * npc_pkg::SQ_W'(diff_b);
	end

	// Palette entry storage
	always_ff @(posedge clk) begin
		if (write_hit) begin
			entry_q <= link_in.color;
		end
	end

	// Stage 1: squares registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pay_s1  <= link_in;
			sq_r_s1 <= sq_r;
			sq_g_s1 <= sq_g;
			sq_b_s1 <= sq_b;
		end
	end

	// Sum and strict compare: earlier cells win ties
	always_comb begin
		dist_sum = npc_pkg::DIST_W'(sq_r_s1) + npc_pkg::DIST_W'(sq_g_s1)
			+ npc_pkg::DIST_W'(sq_b_s1);
		closer   = (pay_s1.func == npc_pkg::FUNC_QUERY) && (dist_sum < pay_s1.best_dist);
		pay_next = pay_s1;
		if (closer) begin
			pay_next.best_dist  = dist_sum;
			pay_next.best_index = CELL_ID;
		end
	end

	// Stage 2: running best registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pay_s2 <= pay_next;
		end
	end

	always_comb begin
		link_out       = pay_s2;
		link_out.valid = vld_s2;
	end

endmodule

`default_nettype wire

### rtl/nearest_palette_color.sv
// ---------------------------------------------------------------------------
// nearest_palette_color: nearest palette color search
// A chain of cells, one per palette entry, that returns the closest entry
// to a query color by squared RGB distance.
// ---------------------------------------------------------------------------
// Usage:
//   query  : input beats. func = write stores {red, green, blue} at
//            entry_index (indexes at or above PALETTE_ENTRIES are dropped);
//            func = query searches the palette for the given color.
//   result : one beat per query, none per write: best_index and
//            best_distance, lowest index on ties.
// Pipeline: two pipeline stages per cell (square, then sum and compare)
//   plus the output register.
// Throughput: one beat per cycle while query.ready is high, writes and queries mixed in any order;
//   a write is seen by every query that follows it.
// Reset: clears all pipeline and output valid flags. Palette contents are
//   not cleared; every entry must be written before it is searched.
// Stall: while result is held off, one finished beat moves into a skid
//   register; once that is full, query.ready drops and the whole chain
//   holds until the result beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
	parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT
) (
	input wire logic     clk,
	input wire logic     arst_n,
	npc_stream_if.sink   query,
	npc_stream_if.source result
);

	npc_pkg::link_t    link [PALETTE_ENTRIES+1];
	npc_pkg::in_beat_t q_beat;
	npc_pkg::link_t    tail;
	npc_pkg::out_beat_t tail_beat;
	logic              advance;
	logic              tail_query;
	logic              take;

	logic               out_valid_q;
	npc_pkg::out_beat_t out_data_q;
	logic               skid_valid_q;
	npc_pkg::out_beat_t skid_data_q;

	// Chain moves unless the skid register is occupied
	assign advance     = !skid_valid_q;
	assign query.ready = advance;

	// Head of chain: fresh search record
	always_comb begin
		q_beat                = query.data;
		link[0].valid         = query.valid;
		link[0].func          = q_beat.func;
		link[0].entry_index   = q_beat.entry_index;
		link[0].color.red     = q_beat.red;
		link[0].color.green   = q_beat.green;
		link[0].color.blue    = q_beat.blue;
		link[0].best_index    = '0;
		link[0].best_dist     = npc_pkg::DIST_START;
	end

	// One cell per palette entry
	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		npc_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.link_in (link[i]),
			.link_out(link[i+1])
		);
	end

	// Tail: only queries produce a result beat
	always_comb begin
		tail                     = link[PALETTE_ENTRIES];
		tail_query               = tail.valid && (tail.func == npc_pkg::FUNC_QUERY);
		tail_beat.best_index     = tail.best_index;
		tail_beat.best_distance  = tail.best_dist;
	end

	assign take = out_valid_q && result.ready;

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance && tail_query) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail_query) begin
			if (!out_valid_q || take) begin
				out_data_q <= tail_beat;
			end else begin
				skid_data_q <= tail_beat;
			end
		end else if (take && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

endmodule

`default_nettype wire

### rtl/npc_checker.sv
// ---------------------------------------------------------------------------
// npc_checker: port-level checks for nearest_palette_color
// Watches the query and result channels and flags behavior that the
// chain and output stage must never show.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_checker #(
	parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEFAULT
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       q_ready,
	input wire logic                       r_valid,
	input wire logic                       r_ready,
	input wire logic [npc_pkg::IDX_W-1:0]  r_index,
	input wire logic [npc_pkg::DIST_W-1:0] r_distance
);

	localparam logic [npc_pkg::DIST_W-1:0] DIST_MAX = npc_pkg::DIST_START - 1'b1;
	localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

	// Stalled result beat holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_index) && $stable(r_distance))
		else $error("result beat changed while stalled");

	// Input is held off only while a result beat is pending
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!q_ready |-> r_valid)
		else $error("query ready low with no result pending");

	// Distance never exceeds three full-scale channel squares
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_distance <= DIST_MAX)
		else $error("result distance out of range");

	// Index always names a palette entry in range
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> {1'b0, r_index} < ENTRY_LIMIT)
		else $error("result index beyond palette");

endmodule

bind nearest_palette_color npc_checker #(
	.PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_npc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.q_ready   (query.ready),
	.r_valid   (result.valid),
	.r_ready   (result.ready),
	.r_index   (result.data.best_index),
	.r_distance(result.data.best_distance)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for nearest_palette_color
// Fills the palette, then runs directed corner cases and random write/query
// traffic under several idle and stall patterns. Every accepted write updates
// a shadow palette. Each query predicts the nearest entry and its squared
// distance, and the result beats are checked in order against those
// predictions.
// ---------------------------------------------------------------------------

module tb_top;

	localparam int N_ENTRIES      = npc_pkg::PALETTE_ENTRIES_DEFAULT;
	localparam int DRAIN_CYCLES   = 2 * N_ENTRIES + 32;
	localparam int TIMEOUT_CYCLES = 300_000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	npc_stream_if #(.T(npc_pkg::in_beat_t))  query_if ();
	npc_stream_if #(.T(npc_pkg::out_beat_t)) result_if ();

	nearest_palette_color #(
		.PALETTE_ENTRIES(N_ENTRIES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_if),
		.result(result_if)
	);

	// Shadow palette and the queue of predicted query results
	npc_pkg::rgb_t      palette_shadow [npc_pkg::STORE_DEPTH];
	npc_pkg::out_beat_t pending_results [$];
	npc_pkg::out_beat_t expected_beat;
	int                 error_count    = 0;
	int                 cycle_count    = 0;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Squared RGB distance between two colors
	function automatic logic [npc_pkg::DIST_W-1:0] color_distance(input npc_pkg::rgb_t a,
		input npc_pkg::rgb_t b);
		int dr, dg, db;
		dr = int'(a.red) - int'(b.red);
		dg = int'(a.green) - int'(b.green);
		db = int'(a.blue) - int'(b.blue);
		return npc_pkg::DIST_W'(dr * dr + dg * dg + db * db);
	endfunction

	// Nearest shadow entry, scanning upward so the lowest index wins a tie
	function automatic npc_pkg::out_beat_t nearest_entry(input npc_pkg::rgb_t color);
		npc_pkg::out_beat_t         best;
		logic [npc_pkg::DIST_W-1:0] d;
		best.best_index    = '0;
		best.best_distance = npc_pkg::DIST_START;
		for (int i = 0; i < N_ENTRIES; i++) begin
			d = color_distance(palette_shadow[i], color);
			if (d < best.best_distance) begin
				best.best_distance = d;
				best.best_index    = npc_pkg::IDX_W'(i);
			end
		end
		return best;
	endfunction

	// Channel value biased toward the extremes
	function automatic logic [npc_pkg::CHAN_W-1:0] pick_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return npc_pkg::CHAN_W'($urandom);
		endcase
	endfunction

	function automatic npc_pkg::rgb_t random_color();
		npc_pkg::rgb_t c;
		c.red   = pick_channel();
		c.green = pick_channel();
		c.blue  = pick_channel();
		return c;
	endfunction

	// Small random offset per channel, clamped to the channel range
	function automatic logic [npc_pkg::CHAN_W-1:0] nudge(input logic [npc_pkg::CHAN_W-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(16)) - 8;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return npc_pkg::CHAN_W'(t);
	endfunction

	function automatic npc_pkg::rgb_t nudge_color(input npc_pkg::rgb_t c);
		npc_pkg::rgb_t n;
		n.red   = nudge(c.red);
		n.green = nudge(c.green);
		n.blue  = nudge(c.blue);
		return n;
	endfunction

	// Send one beat; on acceptance, apply a write to the shadow palette or
	// queue the predicted answer of a query
	task automatic send_beat(input npc_pkg::func_t op, input logic [npc_pkg::IDX_W-1:0] idx,
		input npc_pkg::rgb_t color);
		npc_pkg::in_beat_t beat;
		beat.func        = op;
		beat.entry_index = idx;
		beat.red         = color.red;
		beat.green       = color.green;
		beat.blue        = color.blue;
		while ($urandom_range(99) < send_idle_pct) begin
			query_if.valid <= 1'b0;
			@(posedge clk);
		end
		query_if.valid <= 1'b1;
		query_if.data  <= beat;
		do
			@(posedge clk);
		while (!query_if.ready);
		if (op == npc_pkg::FUNC_WRITE) begin
			if (idx < N_ENTRIES)
				palette_shadow[idx] = color;
		end else begin
			pending_results.push_back(nearest_entry(color));
		end
	endtask

	// Drop valid, wait for every predicted result, then let the chain settle
	task automatic wait_for_drain();
		query_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Every entry black, so that nothing unwritten is ever searched
	task automatic test_fill_black();
		for (int i = 0; i < N_ENTRIES; i++)
			send_beat(npc_pkg::FUNC_WRITE, npc_pkg::IDX_W'(i), '0);
	endtask

	// Largest and zero distance, top entry, ignored index on a query
	task automatic test_extremes();
		send_beat(npc_pkg::FUNC_QUERY, '1, '{red: '1, green: '1, blue: '1});
		send_beat(npc_pkg::FUNC_QUERY, '0, '0);
		send_beat(npc_pkg::FUNC_WRITE, npc_pkg::IDX_W'(N_ENTRIES - 1),
			'{red: '1, green: '1, blue: '1});
		send_beat(npc_pkg::FUNC_QUERY, 8'h5A, '{red: '1, green: '1, blue: '1});
		send_beat(npc_pkg::FUNC_WRITE, '0, '{red: '1, green: '0, blue: '1});
		send_beat(npc_pkg::FUNC_QUERY, 8'hA5, '{red: '0, green: '1, blue: '0});
		send_beat(npc_pkg::FUNC_QUERY, '1, '{red: '1, green: '0, blue: '1});
		send_beat(npc_pkg::FUNC_QUERY, '0, '{red: 8'd128, green: 8'd128, blue: 8'd128});
	endtask

	// Equal colors and equal distances resolve to the lowest index
	task automatic test_ties();
		send_beat(npc_pkg::FUNC_WRITE, 8'd41, '{red: 8'd0, green: 8'd200, blue: 8'd0});
		send_beat(npc_pkg::FUNC_WRITE, 8'd40, '{red: 8'd0, green: 8'd200, blue: 8'd0});
		send_beat(npc_pkg::FUNC_QUERY, 8'd41, '{red: 8'd0, green: 8'd200, blue: 8'd0});
		send_beat(npc_pkg::FUNC_WRITE, 8'd128, '{red: 8'd255, green: 8'd255, blue: 8'd255});
		send_beat(npc_pkg::FUNC_QUERY, '0, '{red: 8'd250, green: 8'd255, blue: 8'd255});
		send_beat(npc_pkg::FUNC_WRITE, 8'd50, '{red: 8'd100, green: 8'd0, blue: 8'd0});
		send_beat(npc_pkg::FUNC_WRITE, 8'd51, '{red: 8'd0, green: 8'd100, blue: 8'd0});
		send_beat(npc_pkg::FUNC_QUERY, '1, '{red: 8'd50, green: 8'd50, blue: 8'd0});
		send_beat(npc_pkg::FUNC_QUERY, '0, '{red: 8'd60, green: 8'd50, blue: 8'd0});
	endtask

	// Mixed traffic: write-then-query pairs, duplicate colors, queries near
	// an entry and queries anywhere in the color cube
	task automatic test_random_traffic(input int n_items);
		int            kind;
		npc_pkg::rgb_t color;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				color = random_color();
				send_beat(npc_pkg::FUNC_WRITE, npc_pkg::IDX_W'($urandom), color);
				send_beat(npc_pkg::FUNC_QUERY, npc_pkg::IDX_W'($urandom), color);
				i++;
			end else if (kind < 35) begin
				color = palette_shadow[$urandom_range(N_ENTRIES - 1)];
				send_beat(npc_pkg::FUNC_WRITE, npc_pkg::IDX_W'($urandom), color);
			end else if (kind < 80) begin
				color = nudge_color(palette_shadow[$urandom_range(N_ENTRIES - 1)]);
				send_beat(npc_pkg::FUNC_QUERY, npc_pkg::IDX_W'($urandom), color);
			end else begin
				send_beat(npc_pkg::FUNC_QUERY, npc_pkg::IDX_W'($urandom), random_color());
			end
		end
	endtask

	// Result ready with random stalls
	always @(posedge clk)
		result_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no query waiting: best_index %0d best_distance %0d",
					result_if.data.best_index, result_if.data.best_distance);
				error_count++;
			end else begin
				expected_beat = pending_results.pop_front();
				if (result_if.data.best_index !== expected_beat.best_index) begin
					$error("best_index: expected %0d, actual %0d",
						expected_beat.best_index, result_if.data.best_index);
					error_count++;
				end
				if (result_if.data.best_distance !== expected_beat.best_distance) begin
					$error("best_distance: expected %0d, actual %0d",
						expected_beat.best_distance, result_if.data.best_distance);
					error_count++;
				end
			end
		end
	end

	// Run-length guard
	initial begin
		while (cycle_count < TIMEOUT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_results.size());
		$display("DONE: errors detected");
		$finish;
	end

	// Test sequence
	initial begin
		query_if.valid <= 1'b0;
		query_if.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_black();
		test_extremes();
		test_ties();

		// no idling
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(45);
		// sender mostly idle
		send_idle_pct  = 66;
		recv_stall_pct = 0;
		test_random_traffic(45);
		// receiver mostly stalled
		send_idle_pct  = 0;
		recv_stall_pct = 66;
		test_random_traffic(45);
		// light idling on both sides
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		test_random_traffic(45);
		wait_for_drain();

		if (pending_results.size() != 0) begin
			$error("%0d query results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
rtl/npc_pkg.sv
rtl/npc_stream_if.sv
rtl/npc_cell.sv
rtl/nearest_palette_color.sv
rtl/npc_checker.sv
tb/sv/tb_top.sv
